// File: rtl/gpio_rb_pkg.sv
// Shared types and register map constants for the GPIO register block.
package gpio_rb_pkg;

    // Transfer kind carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2
    } kind_t;

    localparam int FSEL_WORDS    = 7;
    localparam int FSEL_PER_WORD = 10;
    localparam int FSEL_BITS     = 3;
    localparam int FSEL_WORD_W   = FSEL_PER_WORD * FSEL_BITS;

    localparam logic [2:0] FSEL_OUTPUT = 3'd1;

    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd2;

    // Register word indexes (byte offset / 4).
    localparam logic [5:0] REG_SET0    = 6'd7;
    localparam logic [5:0] REG_SET1    = 6'd8;
    localparam logic [5:0] REG_CLR0    = 6'd10;
    localparam logic [5:0] REG_CLR1    = 6'd11;
    localparam logic [5:0] REG_LEV0    = 6'd13;
    localparam logic [5:0] REG_LEV1    = 6'd14;
    localparam logic [5:0] REG_EDS0    = 6'd16;
    localparam logic [5:0] REG_EDS1    = 6'd17;
    localparam logic [5:0] REG_REN0    = 6'd19;
    localparam logic [5:0] REG_REN1    = 6'd20;
    localparam logic [5:0] REG_FEN0    = 6'd22;
    localparam logic [5:0] REG_FEN1    = 6'd23;
    localparam logic [5:0] REG_HEN0    = 6'd25;
    localparam logic [5:0] REG_HEN1    = 6'd26;
    localparam logic [5:0] REG_LEN0    = 6'd28;
    localparam logic [5:0] REG_LEN1    = 6'd29;
    localparam logic [5:0] REG_AREN0   = 6'd31;
    localparam logic [5:0] REG_AREN1   = 6'd32;
    localparam logic [5:0] REG_AFEN0   = 6'd34;
    localparam logic [5:0] REG_AFEN1   = 6'd35;
    localparam logic [5:0] REG_PUD     = 6'd37;
    localparam logic [5:0] REG_PUDCLK0 = 6'd38;
    localparam logic [5:0] REG_PUDCLK1 = 6'd39;

endpackage

// File: rtl/gpio_register_block.sv
// Top level of the GPIO register block: register file, event detection, stream ports.
//
//  channel  | direction | tuser  | tdata fields (lowest bit first)
//  s_       | in        | kind   | reg_index, write_data, pin_levels
//  m_       | out       | -      | read_data, drive_level, drive_enable, pull_up_mask,
//           |           |        | pull_down_mask, irq_bank0, irq_bank1
//
// One transfer per clock sustained while m_tready is high; each transfer passes through
// the input register, then the register file update into the result register.
// Reset clears every pin control register, the event status and the level history.
// While m_tready is low one more input transfer is taken into the input register,
// then s_tready drops until the result is taken.
module gpio_register_block #(
    parameter int NUM_PINS = 54
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // kind
    input  logic [1:0]                                  s_tuser,
    // reg_index, write_data, pin_levels
    input  logic [((38 + NUM_PINS + 7) / 8) * 8 - 1:0]  s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // read_data, drive_level, drive_enable, pull_up_mask, pull_down_mask,
    // irq_bank0, irq_bank1
    output logic [((34 + 4 * NUM_PINS + 7) / 8) * 8 - 1:0] m_tdata
);
    import gpio_rb_pkg::*;

    localparam int InW  = ((38 + NUM_PINS + 7) / 8) * 8;
    localparam int OutW = ((34 + 4 * NUM_PINS + 7) / 8) * 8;

    typedef logic [NUM_PINS-1:0] pins_t;

    function automatic logic [31:0] bank_word(input pins_t r, input logic bank);
        return bank ? 32'(r >> 32) : r[31:0];
    endfunction

    function automatic pins_t bank_bits(input logic [31:0] d, input logic bank);
        return bank ? NUM_PINS'({d, 32'd0}) : NUM_PINS'(d);
    endfunction

    function automatic pins_t bank_replace(input pins_t r, input logic [31:0] d,
                                           input logic bank);
        return (r & ~bank_bits('1, bank)) | bank_bits(d, bank);
    endfunction

    function automatic logic [FSEL_WORD_W-1:0] fsel_mask(input int unsigned word);
        logic [FSEL_WORD_W-1:0] m;
        m = '0;
        for (int k = 0; k < FSEL_PER_WORD; k++) begin
            if (word * FSEL_PER_WORD + k < NUM_PINS)
                m[FSEL_BITS*k +: FSEL_BITS] = '1;
        end
        return m;
    endfunction

    // input register
    logic        in_valid_reg;
    kind_t       in_kind_reg;
    logic [5:0]  in_idx_reg;
    logic [31:0] in_data_reg;
    pins_t       in_levels_reg;

    // output register
    logic            out_valid_reg;
    logic [OutW-1:0] out_data_reg;

    // pin control state
    logic [FSEL_WORD_W-1:0] fsel_reg  [FSEL_WORDS];
    logic [FSEL_WORD_W-1:0] fsel_next [FSEL_WORDS];
    pins_t latch_reg, latch_next;
    pins_t eds_reg, eds_next;
    pins_t ren_reg, ren_next;
    pins_t fen_reg, fen_next;
    pins_t hen_reg, hen_next;
    pins_t len_reg, len_next;
    pins_t aren_reg, aren_next;
    pins_t afen_reg, afen_next;
    logic [1:0] pud_reg, pud_next;
    pins_t pull_up_reg, pull_up_next;
    pins_t pull_dn_reg, pull_dn_next;
    pins_t prev_reg;

    logic        advance;
    logic        is_read;
    logic        is_write;
    pins_t       cur;
    pins_t       detected;
    pins_t       eds_clear;
    pins_t       drv_en_next;
    logic [31:0] rd_data;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign is_read  = (in_kind_reg == KIND_READ);
    assign is_write = (in_kind_reg == KIND_WRITE);
    assign cur      = in_levels_reg;

    assign detected = (cur & ~prev_reg & (ren_reg | aren_reg))
                    | (prev_reg & ~cur & (fen_reg | afen_reg))
                    | (cur & hen_reg)
                    | (~cur & len_reg);

    // read returns state before this transfer; level reads the current sample
    always_comb begin
        rd_data = '0;
        if (is_read) begin
            if (in_idx_reg < 6'(FSEL_WORDS)) begin
                rd_data = 32'(fsel_reg[in_idx_reg[2:0]]);
            end else begin
                unique case (in_idx_reg)
                    REG_LEV0:  rd_data = bank_word(cur, 1'b0);
                    REG_LEV1:  rd_data = bank_word(cur, 1'b1);
                    REG_EDS0:  rd_data = bank_word(eds_reg, 1'b0);
                    REG_EDS1:  rd_data = bank_word(eds_reg, 1'b1);
                    REG_REN0:  rd_data = bank_word(ren_reg, 1'b0);
                    REG_REN1:  rd_data = bank_word(ren_reg, 1'b1);
                    REG_FEN0:  rd_data = bank_word(fen_reg, 1'b0);
                    REG_FEN1:  rd_data = bank_word(fen_reg, 1'b1);
                    REG_HEN0:  rd_data = bank_word(hen_reg, 1'b0);
                    REG_HEN1:  rd_data = bank_word(hen_reg, 1'b1);
                    REG_LEN0:  rd_data = bank_word(len_reg, 1'b0);
                    REG_LEN1:  rd_data = bank_word(len_reg, 1'b1);
                    REG_AREN0: rd_data = bank_word(aren_reg, 1'b0);
                    REG_AREN1: rd_data = bank_word(aren_reg, 1'b1);
                    REG_AFEN0: rd_data = bank_word(afen_reg, 1'b0);
                    REG_AFEN1: rd_data = bank_word(afen_reg, 1'b1);
                    REG_PUD:   rd_data = 32'(pud_reg);
                    default:   rd_data = '0;
                endcase
            end
        end
    end

    always_comb begin
        for (int w = 0; w < FSEL_WORDS; w++) begin
            fsel_next[w] = fsel_reg[w];
            if (is_write && in_idx_reg == 6'(w))
                fsel_next[w] = in_data_reg[FSEL_WORD_W-1:0] & fsel_mask(w);
        end
    end

    always_comb begin
        latch_next   = latch_reg;
        eds_clear    = '0;
        ren_next     = ren_reg;
        fen_next     = fen_reg;
        hen_next     = hen_reg;
        len_next     = len_reg;
        aren_next    = aren_reg;
        afen_next    = afen_reg;
        pud_next     = pud_reg;
        pull_up_next = pull_up_reg;
        pull_dn_next = pull_dn_reg;
        if (is_write) begin
            unique case (in_idx_reg)
                REG_SET0, REG_SET1:
                    latch_next = latch_reg | bank_bits(in_data_reg, in_idx_reg == REG_SET1);
                REG_CLR0, REG_CLR1:
                    latch_next = latch_reg & ~bank_bits(in_data_reg, in_idx_reg == REG_CLR1);
                REG_EDS0, REG_EDS1:
                    eds_clear = bank_bits(in_data_reg, in_idx_reg == REG_EDS1);
                REG_REN0, REG_REN1:
                    ren_next = bank_replace(ren_reg, in_data_reg, in_idx_reg == REG_REN1);
                REG_FEN0, REG_FEN1:
                    fen_next = bank_replace(fen_reg, in_data_reg, in_idx_reg == REG_FEN1);
                REG_HEN0, REG_HEN1:
                    hen_next = bank_replace(hen_reg, in_data_reg, in_idx_reg == REG_HEN1);
                REG_LEN0, REG_LEN1:
                    len_next = bank_replace(len_reg, in_data_reg, in_idx_reg == REG_LEN1);
                REG_AREN0, REG_AREN1:
                    aren_next = bank_replace(aren_reg, in_data_reg, in_idx_reg == REG_AREN1);
                REG_AFEN0, REG_AFEN1:
                    afen_next = bank_replace(afen_reg, in_data_reg, in_idx_reg == REG_AFEN1);
                REG_PUD:
                    pud_next = in_data_reg[1:0];
                REG_PUDCLK0, REG_PUDCLK1: begin
                    pull_up_next = pull_up_reg
                        & ~bank_bits(in_data_reg, in_idx_reg == REG_PUDCLK1);
                    pull_dn_next = pull_dn_reg
                        & ~bank_bits(in_data_reg, in_idx_reg == REG_PUDCLK1);
                    if (pud_reg == PULL_UP)
                        pull_up_next = pull_up_next
                            | bank_bits(in_data_reg, in_idx_reg == REG_PUDCLK1);
                    else if (pud_reg == PULL_DOWN)
                        pull_dn_next = pull_dn_next
                            | bank_bits(in_data_reg, in_idx_reg == REG_PUDCLK1);
                end
                default: ;
            endcase
        end
        // a new event wins over a clear in the same transfer
        eds_next = (eds_reg & ~eds_clear) | detected;
    end

    for (genvar n = 0; n < NUM_PINS; n++) begin : g_drv_en
        assign drv_en_next[n] =
            fsel_next[n / FSEL_PER_WORD][(n % FSEL_PER_WORD) * FSEL_BITS +: FSEL_BITS]
            == FSEL_OUTPUT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int w = 0; w < FSEL_WORDS; w++)
                fsel_reg[w] <= '0;
            latch_reg     <= '0;
            eds_reg       <= '0;
            ren_reg       <= '0;
            fen_reg       <= '0;
            hen_reg       <= '0;
            len_reg       <= '0;
            aren_reg      <= '0;
            afen_reg      <= '0;
            pud_reg       <= '0;
            pull_up_reg   <= '0;
            pull_dn_reg   <= '0;
            prev_reg      <= '0;
        end else begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance) begin
                fsel_reg    <= fsel_next;
                latch_reg   <= latch_next;
                eds_reg     <= eds_next;
                ren_reg     <= ren_next;
                fen_reg     <= fen_next;
                hen_reg     <= hen_next;
                len_reg     <= len_next;
                aren_reg    <= aren_next;
                afen_reg    <= afen_next;
                pud_reg     <= pud_next;
                pull_up_reg <= pull_up_next;
                pull_dn_reg <= pull_dn_next;
                prev_reg    <= cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg   <= kind_t'(s_tuser);
            in_idx_reg    <= s_tdata[5:0];
            in_data_reg   <= s_tdata[37:6];
            in_levels_reg <= s_tdata[38 +: NUM_PINS];
        end
        if (advance)
            out_data_reg <= OutW'({ |bank_word(eds_next, 1'b1),
                                    |bank_word(eds_next, 1'b0),
                                    pull_dn_next, pull_up_next,
                                    drv_en_next, latch_next, rd_data });
    end

    logic unused_in_pad;
    assign unused_in_pad = ^s_tdata[InW-1:38];

`ifndef SYNTH
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but s_tready low");

    a_pull_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (pull_up_reg & pull_dn_reg) == '0)
        else $error("pin latched with both pull-up and pull-down");

    a_irq0_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[32 + 4 * NUM_PINS] == (|eds_reg[31:0])))
        else $error("irq_bank0 disagrees with event status");

    a_pud_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_write && in_idx_reg == REG_PUD)
            |=> pud_reg == $past(in_data_reg[1:0]))
        else $error("pull control write lost");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the GPIO register block with a transfer-level pin model.
module tb_top;
    import gpio_rb_pkg::*;

    localparam int NUM_PINS      = 54;
    localparam int S_W           = ((38 + NUM_PINS + 7) / 8) * 8;
    localparam int M_W           = ((34 + 4 * NUM_PINS + 7) / 8) * 8;
    localparam int IN_DATA_LSB   = 6;
    localparam int IN_PINS_LSB   = 38;
    localparam int OUT_LEVEL_LSB = 32;
    localparam int OUT_EN_LSB    = OUT_LEVEL_LSB + NUM_PINS;
    localparam int OUT_PU_LSB    = OUT_EN_LSB + NUM_PINS;
    localparam int OUT_PD_LSB    = OUT_PU_LSB + NUM_PINS;
    localparam int OUT_IRQ0      = OUT_PD_LSB + NUM_PINS;
    localparam int OUT_IRQ1      = OUT_IRQ0 + 1;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_GAP       = 8;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [1:0]  KIND_RESERVED   = 2'd3;
    localparam logic [5:0]  REG_UNMAPPED    = 6'd40;
    localparam logic [5:0]  REG_LAST        = 6'd63;
    localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [31:0] FSEL_ALL_OUTPUT = 32'({FSEL_PER_WORD{FSEL_OUTPUT}});
    localparam logic [NUM_PINS-1:0] PINS_LOW  = '0;
    localparam logic [NUM_PINS-1:0] PINS_HIGH = {NUM_PINS{1'b1}};

    typedef struct packed {
        logic                irq1;
        logic                irq0;
        logic [NUM_PINS-1:0] pull_down;
        logic [NUM_PINS-1:0] pull_up;
        logic [NUM_PINS-1:0] drive_enable;
        logic [NUM_PINS-1:0] drive_level;
        logic [31:0]         read_data;
    } gpio_out_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [1:0]     s_tuser;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;

    // pin controller model state
    logic [2:0]          pin_func [NUM_PINS];
    logic [NUM_PINS-1:0] out_latch, evt_status, last_levels;
    logic [NUM_PINS-1:0] rise_en, fall_en, high_en, low_en, arise_en, afall_en;
    logic [NUM_PINS-1:0] pull_up_q, pull_dn_q;
    logic [1:0]          pull_sel;

    gpio_out_t           pending_outputs [$];
    logic [NUM_PINS-1:0] pin_state;
    int                  mismatches;
    int                  tx_max_gap;
    int                  rx_max_gap;
    int                  rx_hold;

    gpio_register_block #(
        .NUM_PINS(NUM_PINS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic logic [31:0] word_of(input logic [NUM_PINS-1:0] v, input bit bank);
        logic [63:0] w;
        w = 64'(v);
        return bank ? w[63:32] : w[31:0];
    endfunction

    function automatic logic [NUM_PINS-1:0] bits_of(input logic [31:0] d, input bit bank);
        logic [63:0] w;
        w = bank ? {d, 32'b0} : {32'b0, d};
        return w[NUM_PINS-1:0];
    endfunction

    function automatic logic [NUM_PINS-1:0] merge_bank(input logic [NUM_PINS-1:0] old,
                                                       input logic [31:0] d, input bit bank);
        return (old & ~bits_of(ALL_ONES, bank)) | bits_of(d, bank);
    endfunction

    function automatic void model_reset();
        for (int n = 0; n < NUM_PINS; n++) pin_func[n] = '0;
        out_latch   = '0;
        evt_status  = '0;
        last_levels = '0;
        rise_en     = '0;
        fall_en     = '0;
        high_en     = '0;
        low_en      = '0;
        arise_en    = '0;
        afall_en    = '0;
        pull_up_q   = '0;
        pull_dn_q   = '0;
        pull_sel    = '0;
    endfunction

    function automatic logic [31:0] read_register(input logic [5:0] idx,
                                                  input logic [NUM_PINS-1:0] levels);
        logic [31:0] r;
        int          pin;
        r = '0;
        if (idx < FSEL_WORDS) begin
            for (int k = 0; k < FSEL_PER_WORD; k++) begin
                pin = int'(idx) * FSEL_PER_WORD + k;
                if (pin < NUM_PINS) r[FSEL_BITS * k +: FSEL_BITS] = pin_func[pin];
            end
            return r;
        end
        case (idx)
            REG_PUD:               r = 32'(pull_sel);
            REG_LEV0, REG_LEV1:    r = word_of(levels, idx == REG_LEV1);
            REG_EDS0, REG_EDS1:    r = word_of(evt_status, idx == REG_EDS1);
            REG_REN0, REG_REN1:    r = word_of(rise_en, idx == REG_REN1);
            REG_FEN0, REG_FEN1:    r = word_of(fall_en, idx == REG_FEN1);
            REG_HEN0, REG_HEN1:    r = word_of(high_en, idx == REG_HEN1);
            REG_LEN0, REG_LEN1:    r = word_of(low_en, idx == REG_LEN1);
            REG_AREN0, REG_AREN1:  r = word_of(arise_en, idx == REG_AREN1);
            REG_AFEN0, REG_AFEN1:  r = word_of(afall_en, idx == REG_AFEN1);
            default:               r = '0;
        endcase
        return r;
    endfunction

    function automatic void write_register(input logic [5:0] idx, input logic [31:0] d);
        logic [NUM_PINS-1:0] sel;
        int                  pin;
        if (idx < FSEL_WORDS) begin
            for (int k = 0; k < FSEL_PER_WORD; k++) begin
                pin = int'(idx) * FSEL_PER_WORD + k;
                if (pin < NUM_PINS) pin_func[pin] = d[FSEL_BITS * k +: FSEL_BITS];
            end
            return;
        end
        case (idx)
            REG_PUD:               pull_sel = d[1:0];
            REG_SET0, REG_SET1:    out_latch |= bits_of(d, idx == REG_SET1);
            REG_CLR0, REG_CLR1:    out_latch &= ~bits_of(d, idx == REG_CLR1);
            REG_EDS0, REG_EDS1:    evt_status &= ~bits_of(d, idx == REG_EDS1);
            REG_PUDCLK0, REG_PUDCLK1: begin
                sel = bits_of(d, idx == REG_PUDCLK1);
                pull_up_q &= ~sel;
                pull_dn_q &= ~sel;
                if (pull_sel == PULL_UP) pull_up_q |= sel;
                else if (pull_sel == PULL_DOWN) pull_dn_q |= sel;
            end
            REG_REN0, REG_REN1:    rise_en  = merge_bank(rise_en, d, idx == REG_REN1);
            REG_FEN0, REG_FEN1:    fall_en  = merge_bank(fall_en, d, idx == REG_FEN1);
            REG_HEN0, REG_HEN1:    high_en  = merge_bank(high_en, d, idx == REG_HEN1);
            REG_LEN0, REG_LEN1:    low_en   = merge_bank(low_en, d, idx == REG_LEN1);
            REG_AREN0, REG_AREN1:  arise_en = merge_bank(arise_en, d, idx == REG_AREN1);
            REG_AFEN0, REG_AFEN1:  afall_en = merge_bank(afall_en, d, idx == REG_AFEN1);
            default: ;
        endcase
    endfunction

    // Events use the enables held before the transfer; a status clear loses to a new event.
    function automatic gpio_out_t predict_gpio_outputs(input logic [1:0] kind,
                                                       input logic [5:0] idx,
                                                       input logic [31:0] d,
                                                       input logic [NUM_PINS-1:0] levels);
        gpio_out_t           r;
        logic [NUM_PINS-1:0] rising, falling, hits;
        rising  = levels & ~last_levels;
        falling = last_levels & ~levels;
        hits    = (rising & (rise_en | arise_en)) | (falling & (fall_en | afall_en))
                | (levels & high_en) | (~levels & low_en);
        r = '0;
        if (kind == KIND_READ) r.read_data = read_register(idx, levels);
        else if (kind == KIND_WRITE) write_register(idx, d);
        evt_status |= hits;
        last_levels = levels;
        for (int n = 0; n < NUM_PINS; n++) r.drive_enable[n] = (pin_func[n] == FSEL_OUTPUT);
        r.drive_level = out_latch;
        r.pull_up     = pull_up_q;
        r.pull_down   = pull_dn_q;
        r.irq0        = |word_of(evt_status, 1'b0);
        r.irq1        = |word_of(evt_status, 1'b1);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Inputs are modeled at the edge they are taken; results are checked at the edge they leave.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_outputs.push_back(predict_gpio_outputs(s_tuser, s_tdata[5:0],
                    s_tdata[IN_DATA_LSB +: 32], s_tdata[IN_PINS_LSB +: NUM_PINS]));
            if (m_tvalid && m_tready) begin
                if (pending_outputs.size() == 0) begin
                    $display("%0t: result transfer with nothing pending, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin : compare_result
                    gpio_out_t want;
                    want = pending_outputs.pop_front();
                    check_field("read_data", want.read_data, m_tdata[31:0]);
                    check_field("drive_level", want.drive_level,
                                m_tdata[OUT_LEVEL_LSB +: NUM_PINS]);
                    check_field("drive_enable", want.drive_enable,
                                m_tdata[OUT_EN_LSB +: NUM_PINS]);
                    check_field("pull_up_mask", want.pull_up, m_tdata[OUT_PU_LSB +: NUM_PINS]);
                    check_field("pull_down_mask", want.pull_down,
                                m_tdata[OUT_PD_LSB +: NUM_PINS]);
                    check_field("irq_bank0", want.irq0, m_tdata[OUT_IRQ0]);
                    check_field("irq_bank1", want.irq1, m_tdata[OUT_IRQ1]);
                end
            end
        end
    end

    // Result sink: random stalls per transfer, plus a long hold when requested.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(input logic [1:0] kind, input logic [5:0] idx,
                             input logic [31:0] d, input logic [NUM_PINS-1:0] levels);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {levels, d, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [NUM_PINS-1:0] rand_pins();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[NUM_PINS-1:0];
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return KIND_SAMPLE;
        if (r < 7) return KIND_READ;
        if (r < 9) return KIND_WRITE;
        return KIND_RESERVED;
    endfunction

    function automatic logic [5:0] pick_reg();
        logic [5:0] bank;
        bank = 6'($urandom_range(0, 1));
        case ($urandom_range(0, 15))
            0:       return 6'($urandom_range(0, FSEL_WORDS - 1));
            1:       return REG_SET0 + bank;
            2:       return REG_CLR0 + bank;
            3:       return REG_LEV0 + bank;
            4:       return REG_EDS0 + bank;
            5:       return REG_REN0 + bank;
            6:       return REG_FEN0 + bank;
            7:       return REG_HEN0 + bank;
            8:       return REG_LEN0 + bank;
            9:       return REG_AREN0 + bank;
            10:      return REG_AFEN0 + bank;
            11:      return REG_PUDCLK0 + bank;
            12:      return REG_PUD;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [5:0] pick_enable_reg();
        logic [5:0] bank;
        bank = 6'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       return REG_REN0 + bank;
            1:       return REG_FEN0 + bank;
            2:       return REG_HEN0 + bank;
            3:       return REG_LEN0 + bank;
            4:       return REG_AREN0 + bank;
            default: return REG_AFEN0 + bank;
        endcase
    endfunction

    task automatic test_directed();
        send_item(KIND_SAMPLE, '0, '0, PINS_LOW);
        send_item(KIND_READ, REG_LEV1, '0, PINS_HIGH);
        // upper word bits of a function select word are dropped
        send_item(KIND_WRITE, 6'd0, ALL_ONES, PINS_HIGH);
        send_item(KIND_READ, 6'd0, '0, PINS_HIGH);
        // last word only partly backed by pins, the one after it not at all
        send_item(KIND_WRITE, 6'(FSEL_WORDS - 2), FSEL_ALL_OUTPUT, PINS_LOW);
        send_item(KIND_WRITE, 6'(FSEL_WORDS - 1), ALL_ONES, PINS_LOW);
        send_item(KIND_READ, 6'(FSEL_WORDS - 1), '0, PINS_LOW);
        send_item(KIND_WRITE, REG_SET0, ALL_ONES, PINS_LOW);
        send_item(KIND_WRITE, REG_SET1, ALL_ONES, PINS_LOW);
        send_item(KIND_WRITE, REG_CLR1, 32'h0000_FFFF, PINS_LOW);
        send_item(KIND_READ, REG_SET0, '0, PINS_LOW);
        send_item(KIND_WRITE, REG_LEV0, ALL_ONES, PINS_LOW);
        send_item(KIND_WRITE, REG_PUD, 32'hFFFF_FFFE, PINS_LOW);
        send_item(KIND_WRITE, REG_PUDCLK0, ALL_ONES, PINS_LOW);
        send_item(KIND_WRITE, REG_PUD, 32'(PULL_DOWN), PINS_LOW);
        send_item(KIND_WRITE, REG_PUDCLK1, ALL_ONES, PINS_LOW);
        send_item(KIND_WRITE, REG_PUD, ALL_ONES, PINS_LOW);
        send_item(KIND_WRITE, REG_PUDCLK0, 32'h0000_00FF, PINS_LOW);
        send_item(KIND_READ, REG_PUD, '0, PINS_LOW);
        send_item(KIND_READ, REG_PUDCLK0, '0, PINS_LOW);
        // rise on bank 0, then a clear in the same transfer as a new edge
        send_item(KIND_WRITE, REG_REN0, ALL_ONES, PINS_LOW);
        send_item(KIND_SAMPLE, '0, '0, PINS_HIGH);
        send_item(KIND_SAMPLE, '0, '0, PINS_LOW);
        send_item(KIND_WRITE, REG_EDS0, ALL_ONES, PINS_HIGH);
        send_item(KIND_WRITE, REG_LEN1, ALL_ONES, PINS_LOW);
        send_item(KIND_READ, REG_EDS1, '0, PINS_LOW);
        send_item(KIND_RESERVED, REG_EDS0, ALL_ONES, PINS_HIGH);
        send_item(KIND_READ, REG_LAST, '0, PINS_HIGH);
        send_item(KIND_WRITE, REG_UNMAPPED, ALL_ONES, PINS_HIGH);
        pin_state = PINS_HIGH;
    endtask

    task automatic test_register_map();
        repeat (150) begin
            if ($urandom_range(0, 3) == 0) pin_state = rand_pins();
            send_item(pick_kind(), pick_reg(), rand_word(), pin_state);
        end
    endtask

    task automatic test_event_detect();
        logic [5:0] bank;
        for (int round = 0; round < 16; round++) begin
            // back half runs with no idle cycles on either side
            tx_max_gap = (round < 8) ? MAX_GAP : 0;
            rx_max_gap = (round < 8) ? MAX_GAP : 0;
            repeat ($urandom_range(1, 4))
                send_item(KIND_WRITE, pick_enable_reg(), rand_word(), pin_state);
            repeat ($urandom_range(8, 16)) begin
                pin_state ^= ($urandom_range(0, 5) == 0) ? rand_pins()
                                                          : rand_pins() & rand_pins() & rand_pins();
                bank = 6'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0)
                    send_item(KIND_READ, REG_EDS0 + bank, $urandom, pin_state);
                else
                    send_item(KIND_SAMPLE, 6'($urandom_range(0, 63)), $urandom, pin_state);
            end
            bank = 6'($urandom_range(0, 1));
            send_item(KIND_WRITE, REG_EDS0 + bank, rand_word(), pin_state);
        end
        tx_max_gap = MAX_GAP;
        rx_max_gap = MAX_GAP;
    endtask

    task automatic test_pull_and_drive();
        logic [5:0] bank;
        repeat (20) begin
            bank = 6'($urandom_range(0, 1));
            send_item(KIND_WRITE, REG_PUD, $urandom, pin_state);
            send_item(KIND_WRITE, REG_PUDCLK0 + bank, rand_word(), pin_state);
            send_item(KIND_WRITE, 6'($urandom_range(0, FSEL_WORDS - 1)),
                      ($urandom_range(0, 2) == 0) ? FSEL_ALL_OUTPUT : $urandom, pin_state);
            send_item(KIND_WRITE, ($urandom_range(0, 1) ? REG_SET0 : REG_CLR0) + bank,
                      rand_word(), pin_state);
            send_item(KIND_READ, pick_reg(), $urandom, pin_state);
        end
    endtask

    // Sink stops for a long stretch while the source keeps offering back to back.
    task automatic test_backpressure();
        rx_hold    = HOLD_CYCLES;
        tx_max_gap = 0;
        repeat (40) begin
            pin_state ^= rand_pins() & rand_pins();
            send_item(pick_kind(), pick_reg(), rand_word(), pin_state);
        end
        tx_max_gap = MAX_GAP;
    endtask

    initial begin
        s_tvalid   = 1'b0;
        s_tuser    = '0;
        s_tdata    = '0;
        aresetn    = 1'b0;
        mismatches = 0;
        tx_max_gap = MAX_GAP;
        rx_max_gap = MAX_GAP;
        rx_hold    = 0;
        pin_state  = '0;
        model_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_register_map();
        test_event_detect();
        test_pull_and_drive();
        test_backpressure();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/gpio_rb_pkg.sv
rtl/gpio_register_block.sv
verif/tb_top.sv
